// ===== hdl/kqt_pkg.sv =====
// ----------------------------------------------------------------------------
// kqt_pkg
// shared types for the keyed quantity table: request modes, result codes,
// table entry layout and the memory control group
// ----------------------------------------------------------------------------
package kqt_pkg;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_UPDATE = 2'd2,
    MODE_LIST   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  // one table entry, key and quantity side by side in one memory word
  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] qty;
  } entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// ===== hdl/kqt_mem.sv =====
// ----------------------------------------------------------------------------
// kqt_mem
// entry memory: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module kqt_mem import kqt_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  mem_ctl_t         ctl,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t entry_mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= entry_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/kqt_ctrl.sv =====
// ----------------------------------------------------------------------------
// kqt_ctrl
// request sequencer: pipelined key scan, read-modify-write of the matched
// entry, list walk and the result register
// ----------------------------------------------------------------------------
module kqt_ctrl import kqt_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6,
  parameter int CNT_W = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_key,
  input  logic signed [31:0] in_amount,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_entry_key,
  output logic signed [31:0] out_quantity,
  output logic               out_last,
  output mem_ctl_t           mem_ctl,
  output logic [IDX_W-1:0]   mem_wr_addr,
  output entry_t             mem_wr_data,
  output logic [IDX_W-1:0]   mem_rd_addr,
  input  entry_t             mem_rd_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LIST,
    S_RESP
  } state_t;

  state_t             state_r, state_nxt;
  mode_t              mode_r, mode_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic signed [31:0] amount_r, amount_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   pend_idx_r, pend_idx_nxt;
  status_t            resp_status_r, resp_status_nxt;
  logic signed [31:0] resp_key_r, resp_key_nxt;
  logic signed [31:0] resp_qty_r, resp_qty_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic signed [31:0] out_key_r, out_key_nxt;
  logic signed [31:0] out_qty_r, out_qty_nxt;
  logic               out_last_r, out_last_nxt;

  logic               slot_free;
  logic               table_full;
  logic [CNT_W-1:0]   count_last;
  logic [CNT_W-1:0]   rd_idx_inc;
  logic               match;
  logic               at_last;
  logic signed [32:0] sum;
  logic signed [31:0] sat_qty;

  assign slot_free  = !out_valid_r || out_ready;
  assign table_full = (count_r == CNT_W'(DEPTH));
  assign count_last = count_r - CNT_W'(1);
  assign rd_idx_inc = rd_idx_r + CNT_W'(1);
  assign match      = pend_r && (mem_rd_data.key == key_r);
  assign at_last    = (CNT_W'(pend_idx_r) == count_last);

  // saturating add of the stored quantity and the change
  assign sum = {mem_rd_data.qty[31], mem_rd_data.qty} + {amount_r[31], amount_r};
  always_comb begin
    if (sum[32] != sum[31]) begin
      sat_qty = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_qty = sum[31:0];
    end
  end

  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    key_nxt         = key_r;
    amount_nxt      = amount_r;
    count_nxt       = count_r;
    rd_idx_nxt      = rd_idx_r;
    pend_nxt        = pend_r;
    pend_idx_nxt    = pend_idx_r;
    resp_status_nxt = resp_status_r;
    resp_key_nxt    = resp_key_r;
    resp_qty_nxt    = resp_qty_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_key_nxt     = out_key_r;
    out_qty_nxt     = out_qty_r;
    out_last_nxt    = out_last_r;
    mem_ctl         = '0;
    mem_wr_addr     = pend_idx_r;
    mem_wr_data     = '{key: key_r, qty: sat_qty};
    mem_rd_addr     = rd_idx_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt     = mode_t'(in_mode);
          key_nxt      = in_key;
          amount_nxt   = in_amount;
          resp_key_nxt = in_key;
          resp_qty_nxt = '0;
          if (mode_t'(in_mode) == MODE_INSERT && table_full) begin
            resp_status_nxt = ST_FULL;
            state_nxt       = S_RESP;
          end else if (mode_t'(in_mode) == MODE_LIST) begin
            if (count_r == '0) begin
              resp_status_nxt = ST_EMPTY;
              resp_key_nxt    = '0;
              state_nxt       = S_RESP;
            end else begin
              mem_ctl.rd_en = 1'b1;
              mem_rd_addr   = '0;
              rd_idx_nxt    = '0;
              state_nxt     = S_LIST;
            end
          end else if (count_r == '0) begin
            if (mode_t'(in_mode) == MODE_INSERT) begin
              mem_ctl.wr_en   = 1'b1;
              mem_wr_addr     = '0;
              mem_wr_data     = '{key: in_key, qty: in_amount};
              count_nxt       = count_r + CNT_W'(1);
              resp_status_nxt = ST_OK;
              resp_qty_nxt    = in_amount;
            end else begin
              resp_status_nxt = ST_NOT_FOUND;
            end
            state_nxt = S_RESP;
          end else begin
            mem_ctl.rd_en = 1'b1;
            mem_rd_addr   = '0;
            rd_idx_nxt    = CNT_W'(1);
            pend_nxt      = 1'b1;
            pend_idx_nxt  = '0;
            state_nxt     = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // one read issued and one compare done per cycle
        mem_ctl.rd_en = (rd_idx_r < count_r);
        pend_nxt      = mem_ctl.rd_en;
        pend_idx_nxt  = rd_idx_r[IDX_W-1:0];
        if (mem_ctl.rd_en) begin
          rd_idx_nxt = rd_idx_inc;
        end
        if (pend_r && (match || at_last)) begin
          state_nxt    = S_RESP;
          resp_qty_nxt = '0;
          case (mode_r)
            MODE_INSERT: begin
              if (match) begin
                resp_status_nxt = ST_EXISTS;
                resp_qty_nxt    = mem_rd_data.qty;
              end else begin
                mem_ctl.wr_en   = 1'b1;
                mem_wr_addr     = count_r[IDX_W-1:0];
                mem_wr_data     = '{key: key_r, qty: amount_r};
                count_nxt       = count_r + CNT_W'(1);
                resp_status_nxt = ST_OK;
                resp_qty_nxt    = amount_r;
              end
            end
            MODE_LOOKUP: begin
              if (match) begin
                resp_status_nxt = ST_OK;
                resp_qty_nxt    = mem_rd_data.qty;
              end else begin
                resp_status_nxt = ST_NOT_FOUND;
              end
            end
            MODE_UPDATE: begin
              if (match) begin
                mem_ctl.wr_en   = 1'b1;
                mem_wr_addr     = pend_idx_r;
                mem_wr_data     = '{key: key_r, qty: sat_qty};
                resp_status_nxt = ST_OK;
                resp_qty_nxt    = sat_qty;
              end else begin
                resp_status_nxt = ST_NOT_FOUND;
              end
            end
            default: begin
              resp_status_nxt = ST_NOT_FOUND;
            end
          endcase
        end
      end

      S_LIST: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_key_nxt    = mem_rd_data.key;
          out_qty_nxt    = mem_rd_data.qty;
          out_last_nxt   = (rd_idx_r == count_last);
          if (rd_idx_r == count_last) begin
            state_nxt = S_IDLE;
          end else begin
            mem_ctl.rd_en = 1'b1;
            mem_rd_addr   = rd_idx_inc[IDX_W-1:0];
            rd_idx_nxt    = rd_idx_inc;
          end
        end
      end

      S_RESP: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = resp_status_r;
          out_key_nxt    = resp_key_r;
          out_qty_nxt    = resp_qty_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      mode_r        <= mode_nxt;
      key_r         <= key_nxt;
      amount_r      <= amount_nxt;
      count_r       <= count_nxt;
      rd_idx_r      <= rd_idx_nxt;
      pend_r        <= pend_nxt;
      pend_idx_r    <= pend_idx_nxt;
      resp_status_r <= resp_status_nxt;
      resp_key_r    <= resp_key_nxt;
      resp_qty_r    <= resp_qty_nxt;
      out_valid_r   <= out_valid_nxt;
      out_status_r  <= out_status_nxt;
      out_key_r     <= out_key_nxt;
      out_qty_r     <= out_qty_nxt;
      out_last_r    <= out_last_nxt;
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_entry_key = out_key_r;
  assign out_quantity  = out_qty_r;
  assign out_last      = out_last_r;

endmodule

// ===== hdl/keyed_quantity_table_unit.sv =====
// ----------------------------------------------------------------------------
// keyed_quantity_table_unit
// keyed table of signed quantities with insert, lookup, update and list
// ----------------------------------------------------------------------------
// the table keeps up to TABLE_DEPTH entries of a 32-bit key and a 32-bit
// signed quantity in one single-port-read, single-port-write memory, in
// insertion order. keys are found by a scan from the oldest entry, one
// entry compared per cycle through the memory read port; the scan stops at
// the first match. a full insert, an empty list or a request on an empty
// table is answered without a scan. a list request emits one item per
// entry at up to one item per cycle. a new request is taken once the
// previous one has placed its last result in the output register, even
// while that result still waits to be taken. no clearing pass runs after
// reset: only entries below the fill count are ever read.
module keyed_quantity_table_unit import kqt_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_key,
  input  logic signed [31:0] in_amount,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_entry_key,
  output logic signed [31:0] out_quantity,
  output logic               out_last
);

  // address width of the memory, count width holds the depth itself
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  mem_ctl_t         mem_ctl;
  logic [IDX_W-1:0] mem_wr_addr;
  entry_t           mem_wr_data;
  logic [IDX_W-1:0] mem_rd_addr;
  entry_t           mem_rd_data;

  // sequencer: accepts requests, runs the scan or list walk and owns the
  // result register; the matched entry is written back in the same cycle
  // it is compared, and the next request cannot read before that write
  kqt_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_key        (in_key),
    .in_amount     (in_amount),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_entry_key (out_entry_key),
    .out_quantity  (out_quantity),
    .out_last      (out_last),
    .mem_ctl       (mem_ctl),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data)
  );

  // entry storage, read data registered, valid in the cycle after the read
  kqt_mem #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

// ===== hdl/kqt_checker.sv =====
// ----------------------------------------------------------------------------
// kqt_checker
// port-level checks of the keyed quantity table, bound to the top level
// ----------------------------------------------------------------------------
module kqt_checker import kqt_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_status,
  input logic signed [31:0] out_entry_key,
  input logic signed [31:0] out_quantity,
  input logic               out_last
);

  // requests accepted whose last result has not been taken
  logic [1:0] open_r, open_nxt;
  logic       in_acc;
  logic       last_acc;

  assign in_acc   = in_valid && in_ready;
  assign last_acc = out_valid && out_ready && out_last;

  always_comb begin
    open_nxt = open_r;
    if (in_acc && !last_acc) begin
      open_nxt = open_r + 2'd1;
    end else if (!in_acc && last_acc) begin
      open_nxt = open_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else begin
      open_r <= open_nxt;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_entry_key) && $stable(out_quantity) && $stable(out_last))
    else $error("stalled result changed");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == ST_OK)
    else $error("non-final item carries an error status");

  a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> open_r != 2'd0)
    else $error("result item with no open request");

  a_one_request_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    open_r != 2'd3)
    else $error("more than one request taken ahead of its result");

endmodule

bind keyed_quantity_table_unit kqt_checker u_kqt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_status    (out_status),
  .out_entry_key (out_entry_key),
  .out_quantity  (out_quantity),
  .out_last      (out_last)
);

// ===== sim/keyed_quantity_table_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_quantity_table_unit_tb
// self-checking bench for the keyed quantity table: a shadow inventory
// predicts every result of every accepted request, a monitor on the result
// channel compares each result field by field, and the sender and receiver
// idle at random so that requests and results meet the block at every phase
// of its key scan and list walk
// ----------------------------------------------------------------------------
module keyed_quantity_table_unit_tb;
  import kqt_pkg::*;

  localparam int TABLE_DEPTH    = 64;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // one result as it should leave the block
  typedef struct {
    status_t            status;
    logic signed [31:0] entry_key;
    logic signed [31:0] quantity;
    logic               last;
  } report_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [1:0]         in_mode   = MODE_INSERT;
  logic signed [31:0] in_key    = '0;
  logic signed [31:0] in_amount = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_status;
  logic signed [31:0] out_entry_key;
  logic signed [31:0] out_quantity;
  logic               out_last;

  // shadow copy of the table, updated in acceptance order
  logic signed [31:0] inv_keys [TABLE_DEPTH];
  logic signed [31:0] inv_qty  [TABLE_DEPTH];
  int                 inv_count;

  // results owed by the block, oldest first
  report_t reports_due[$];

  int error_count = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  // receiver stall pattern
  int ready_style = 0;
  int ready_hold  = 0;
  int ready_tick  = 0;

  always #2 clk = ~clk;

  keyed_quantity_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_key       (in_key),
    .in_amount    (in_amount),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_entry_key(out_entry_key),
    .out_quantity (out_quantity),
    .out_last     (out_last)
  );

  // --------------------------------------------------------------------------
  // inventory prediction
  // --------------------------------------------------------------------------

  // linear scan from the oldest entry, first match wins
  function automatic int find_slot(logic signed [31:0] k);
    for (int i = 0; i < inv_count; i++) begin
      if (inv_keys[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic void owe_report(status_t s, logic signed [31:0] k,
                                     logic signed [31:0] q, logic last);
    report_t r;
    r.status    = s;
    r.entry_key = k;
    r.quantity  = q;
    r.last      = last;
    reports_due.push_back(r);
  endfunction

  function automatic void apply_to_inventory(mode_t m, logic signed [31:0] k,
                                             logic signed [31:0] amt);
    int     slot;
    longint sum;
    slot = find_slot(k);
    case (m)
      MODE_INSERT: begin
        // a full table refuses before the duplicate check
        if (inv_count >= TABLE_DEPTH) begin
          owe_report(ST_FULL, k, '0, 1'b1);
        end else if (slot >= 0) begin
          owe_report(ST_EXISTS, k, inv_qty[slot], 1'b1);
        end else begin
          inv_keys[inv_count] = k;
          inv_qty[inv_count]  = amt;
          inv_count++;
          owe_report(ST_OK, k, amt, 1'b1);
        end
      end
      MODE_LOOKUP: begin
        if (slot < 0) owe_report(ST_NOT_FOUND, k, '0, 1'b1);
        else owe_report(ST_OK, k, inv_qty[slot], 1'b1);
      end
      MODE_UPDATE: begin
        if (slot < 0) begin
          owe_report(ST_NOT_FOUND, k, '0, 1'b1);
        end else begin
          // saturating signed add
          sum = longint'(inv_qty[slot]) + longint'(amt);
          if (sum > longint'(Q_MAX)) inv_qty[slot] = Q_MAX;
          else if (sum < longint'(Q_MIN)) inv_qty[slot] = Q_MIN;
          else inv_qty[slot] = 32'(sum);
          owe_report(ST_OK, k, inv_qty[slot], 1'b1);
        end
      end
      default: begin
        // list walks every entry in insertion order
        if (inv_count == 0) begin
          owe_report(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < inv_count; i++) begin
            owe_report(ST_OK, inv_keys[i], inv_qty[i], i == inv_count - 1);
          end
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic signed [31:0] pick_amount();
    case ($urandom_range(0, 7))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return $signed($urandom_range(0, 200)) - 100;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_fresh_key();
    case ($urandom_range(0, 11))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return '0;
      3:       return -1;
      4:       return $urandom_range(0, 15);  // small keys collide often
      default: return $urandom;
    endcase
  endfunction

  // mostly keys already in the table, so the scan finds something
  function automatic logic signed [31:0] pick_stored_key();
    if (inv_count == 0 || $urandom_range(0, 4) == 0) return pick_fresh_key();
    return inv_keys[$urandom_range(0, inv_count - 1)];
  endfunction

  // one request: bursts of back-to-back items with random gaps between them
  task automatic send_request(mode_t m, logic signed [31:0] k,
                              logic signed [31:0] amt);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      // short gaps mostly, now and then a long one
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(20, 90)
                                          : $urandom_range(1, 8))
        @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 6);
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_mode   <= m;
    in_key    <= k;
    in_amount <= amt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_to_inventory(m, k, amt);
  endtask

  // sender holds off until every owed result has come back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (reports_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_request();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      // a few inserts reuse a stored key to hit the duplicate path
      if (inv_count > 0 && $urandom_range(0, 7) == 0)
        send_request(MODE_INSERT, pick_stored_key(), pick_amount());
      else
        send_request(MODE_INSERT, pick_fresh_key(), pick_amount());
    end else if (roll < 60) begin
      send_request(MODE_LOOKUP, pick_stored_key(), $urandom);
    end else if (roll < 93) begin
      send_request(MODE_UPDATE, pick_stored_key(), pick_amount());
    end else begin
      send_request(MODE_LIST, $urandom, $urandom);
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // list, lookup and update on a table with nothing in it
  task automatic test_empty_table();
    send_request(MODE_LIST, $urandom, $urandom);
    send_request(MODE_LOOKUP, '0, $urandom);
    send_request(MODE_UPDATE, -1, 32'sd5);
  endtask

  // extreme keys and quantities, then a duplicate with a different amount
  task automatic test_insert_cases();
    send_request(MODE_INSERT, Q_MIN, Q_MAX);
    send_request(MODE_INSERT, Q_MAX, Q_MIN);
    send_request(MODE_INSERT, '0, '0);
    send_request(MODE_INSERT, -1, 32'sd1);
    send_request(MODE_INSERT, Q_MIN, 32'sd77);
  endtask

  // hits, misses and saturation at both ends
  task automatic test_lookup_and_update();
    send_request(MODE_LOOKUP, Q_MAX, $urandom);
    send_request(MODE_UPDATE, Q_MAX, -1);          // min - 1 clamps low
    send_request(MODE_UPDATE, Q_MIN, 32'sd1);      // max + 1 clamps high
    send_request(MODE_UPDATE, '0, Q_MIN);
    send_request(MODE_UPDATE, '0, Q_MAX);          // lands on -1 exactly
    send_request(MODE_UPDATE, -1, Q_MAX);          // 1 + max clamps high
    send_request(MODE_LOOKUP, 32'sd12345, $urandom);
    send_request(MODE_LOOKUP, 32'sd1, $urandom);
    send_request(MODE_LIST, $urandom, $urandom);
  endtask

  // random traffic, at least 200 requests and until the table has filled
  task automatic test_fill_table();
    for (int n = 0; n < 200 || inv_count < TABLE_DEPTH; n++) send_random_request();
  endtask

  // full table: fullness wins over the duplicate check, lists run 64 long
  task automatic test_full_table();
    send_request(MODE_INSERT, inv_keys[0], pick_amount());
    send_request(MODE_INSERT, pick_fresh_key(), pick_amount());
    for (int n = 0; n < 80; n++) send_random_request();
  endtask

  // --------------------------------------------------------------------------
  // result monitor and receiver stalls
  // --------------------------------------------------------------------------

  function automatic void check_field(string name, logic signed [32:0] want,
                                      logic signed [32:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d",
               $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (reports_due.size() == 0) begin
        error_count++;
        $display("%0t ns: result with none owed, expected none, actual %0d %0d %0d %0d",
                 $time, out_status, out_entry_key, out_quantity, out_last);
      end else begin
        want = reports_due.pop_front();
        check_field("status", want.status, out_status);
        check_field("entry_key", want.entry_key, out_entry_key);
        check_field("quantity", want.quantity, out_quantity);
        check_field("last", want.last, out_last);
      end
    end

    // receiver style is redrawn whenever its random hold runs out
    if (ready_hold == 0) begin
      ready_style = $urandom_range(0, 3);
      ready_hold  = $urandom_range(20, 200);
    end else begin
      ready_hold--;
    end
    ready_tick++;
    case (ready_style)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ($urandom_range(0, 4) == 0);
      default: out_ready <= (ready_tick % 4 == 3);  // periodic stalls driven by ready_tick
    endcase
  end

  // watchdog on cycles with no item taken on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("keyed_quantity_table_unit_tb: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------

  initial begin
    inv_count = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_insert_cases();
    test_lookup_and_update();
    wait_for_drain();
    test_fill_table();
    test_full_table();

    // let the last scan finish and catch anything extra
    wait_for_drain();
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (reports_due.size() != 0) begin
      error_count++;
      $display("%0t ns: results missing, expected %0d more, actual 0",
               $time, reports_due.size());
    end

    if (error_count == 0) begin
      $display("keyed_quantity_table_unit_tb: done, clean");
    end else begin
      $display("keyed_quantity_table_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
